@@ src/shortest_path_dense_graph_top_defines.svh @@
// Assertion macros for the shortest path block.
`ifndef SHORTEST_PATH_DENSE_GRAPH_TOP_DEFINES_SVH
`define SHORTEST_PATH_DENSE_GRAPH_TOP_DEFINES_SVH
`define SPDG_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SPDG_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/spdg_pkg.sv @@
// Package: payload types, state enum and constants of the shortest path block.
`default_nettype none
package spdg_pkg;
  localparam int MAX_NODES   = 32;
  localparam int WEIGHT_BITS = 16;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;
  localparam logic [21:0] DIST_INF = 22'h3FFFFF;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [15:0] edge_weight;
    logic [4:0]  source_node;
    logic [4:0]  target_node;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  node;
    logic [21:0] distance;
    logic [4:0]  predecessor;
    logic        settled;
    logic        reachable;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RELAX_REQ, ST_RELAX, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

@@ src/spdg_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module spdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/spdg_front.sv @@
// Front part: input item queue of two entries.
`default_nettype none
module spdg_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spdg_pkg::in_item_t in_item,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output spdg_pkg::in_item_t      q_item
);
  spdg_pkg::in_item_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ src/spdg_back.sv @@
// Back part: weight store writes and the Dijkstra sequencer with result output.
`default_nettype none
module spdg_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [5:0]          n_use,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire spdg_pkg::in_item_t  q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spdg_pkg::out_item_t      out_item,
  output logic                     busy
);
  localparam int NB = $clog2(spdg_pkg::MAX_NODES);
  localparam int AB = 2 * NB;

  logic [21:0]   dist_tab [spdg_pkg::MAX_NODES];
  logic [4:0]    pred [spdg_pkg::MAX_NODES];
  logic [spdg_pkg::MAX_NODES-1:0] vis;

  spdg_pkg::state_t state, state_next;
  logic [NB-1:0] j;
  logic [NB-1:0] pick;
  logic          found;
  logic [21:0]   pick_dist;
  logic [NB:0]   n_ext;
  logic [4:0]    dst;
  logic          src_ok;

  logic          we;
  logic [AB-1:0] waddr, raddr;
  logic [spdg_pkg::WEIGHT_BITS-1:0] wdata, rdata;
  logic          jlast;

  assign n_ext = n_use[NB:0];
  assign jlast = ({1'b0, j} == n_ext - 1'b1);
  assign src_ok = ({1'b0, q_item.source_node} < 6'(n_ext));
  assign we    = (state == spdg_pkg::ST_IDLE) && q_valid &&
                 (q_item.opcode == spdg_pkg::OP_LOAD) &&
                 (q_item.from_node < spdg_pkg::MAX_NODES) &&
                 (q_item.to_node < spdg_pkg::MAX_NODES);
  assign waddr = {q_item.from_node[NB-1:0], q_item.to_node[NB-1:0]};
  assign wdata = q_item.edge_weight[spdg_pkg::WEIGHT_BITS-1:0];
  assign raddr = {pick, j};

  spdg_ram #(
    .WIDTH(spdg_pkg::WEIGHT_BITS),
    .DEPTH(spdg_pkg::MAX_NODES * spdg_pkg::MAX_NODES)
  ) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // relax arithmetic, rj is one behind the RAM address j in ST_RELAX
  logic [NB-1:0] rj;
  logic [22:0]   sum;
  logic [21:0]   sum_sat;
  assign sum     = {1'b0, pick_dist} + 23'(rdata);
  assign sum_sat = (sum >= 23'(spdg_pkg::DIST_INF)) ? spdg_pkg::DIST_INF : sum[21:0];

  always_comb begin
    state_next = state;
    unique case (state)
      spdg_pkg::ST_IDLE:
        if (q_valid && q_item.opcode == spdg_pkg::OP_RUN) state_next = spdg_pkg::ST_SCAN;
      spdg_pkg::ST_SCAN:
        if (jlast) begin
          if (!found && !(!vis[j] && dist_tab[j] != spdg_pkg::DIST_INF)) begin
            state_next = spdg_pkg::ST_EMIT;
          end else begin
            state_next = spdg_pkg::ST_RELAX_REQ;
          end
        end
      spdg_pkg::ST_RELAX_REQ: state_next = spdg_pkg::ST_RELAX;
      spdg_pkg::ST_RELAX:
        if ({1'b0, rj} == n_ext - 1'b1) begin
          state_next = (pick == dst) ? spdg_pkg::ST_EMIT : spdg_pkg::ST_SCAN;
        end
      spdg_pkg::ST_EMIT:
        if (out_ready && jlast) state_next = spdg_pkg::ST_IDLE;
      default: state_next = spdg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == spdg_pkg::ST_IDLE);
    out_valid = (state == spdg_pkg::ST_EMIT);
    busy      = (state != spdg_pkg::ST_IDLE) || q_valid;
    out_item.node        = 5'(j);
    out_item.distance    = dist_tab[j];
    out_item.predecessor = pred[j];
    out_item.settled     = vis[j];
    out_item.reachable   = (dist_tab[j] != spdg_pkg::DIST_INF);
    out_item.last        = jlast;
  end

  logic cand;
  assign cand = !vis[j] && dist_tab[j] != spdg_pkg::DIST_INF &&
                (!found || dist_tab[j] < pick_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spdg_pkg::ST_IDLE;
      vis   <= '0;
      j     <= '0;
      found <= 1'b0;
      for (int i = 0; i < spdg_pkg::MAX_NODES; i++) begin
        dist_tab[i] <= spdg_pkg::DIST_INF;
        pred[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        spdg_pkg::ST_IDLE: begin
          j <= '0;
          found <= 1'b0;
          if (q_valid && q_item.opcode == spdg_pkg::OP_RUN) begin
            dst <= q_item.target_node;
            vis <= '0;
            for (int i = 0; i < spdg_pkg::MAX_NODES; i++) begin
              if (src_ok && q_item.source_node == 5'(i)) begin
                dist_tab[i] <= '0;
                pred[i] <= q_item.source_node;
              end else begin
                dist_tab[i] <= spdg_pkg::DIST_INF;
                pred[i] <= '0;
              end
            end
          end
        end
        spdg_pkg::ST_SCAN: begin
          if (cand) begin
            pick <= j;
            pick_dist <= dist_tab[j];
            found <= 1'b1;
          end
          if (jlast) begin
            j <= '0;
            if (found || cand) vis[cand ? j : pick] <= 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        spdg_pkg::ST_RELAX_REQ: begin
          rj <= '0;
          j  <= jlast ? j : j + 1'b1;
        end
        spdg_pkg::ST_RELAX: begin
          if (!vis[rj] && rdata != '0 && sum_sat < dist_tab[rj]) begin
            dist_tab[rj] <= sum_sat;
            pred[rj] <= 5'(pick);
          end
          rj <= rj + 1'b1;
          if ({1'b0, rj} == n_ext - 1'b1) begin
            j <= '0;
            found <= 1'b0;
          end else begin
            j <= jlast ? j : j + 1'b1;
          end
        end
        spdg_pkg::ST_EMIT:
          if (out_ready) j <= jlast ? '0 : j + 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/shortest_path_dense_graph_top.sv @@
// Load items: one per cycle while no run is in progress, written into the weight store
// from the input queue. Run items: each round settles the nearest unsettled node and
// relaxes its edges; then one result per node, one per cycle while the output is taken.
// Synchronous active-high reset clears control, tables and sets node_count to 32;
// the weight store is not cleared.
`default_nettype none
`include "shortest_path_dense_graph_top_defines.svh"
module shortest_path_dense_graph_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire spdg_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output spdg_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [5:0]          cfg_wdata
);
  logic [5:0] node_count, n_use;
  logic q_valid, q_ready, busy;
  spdg_pkg::in_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) node_count <= 6'd32;
    else if (cfg_we) node_count <= cfg_wdata;
  end
  assign n_use = (node_count == '0) ? 6'd1 :
                 (32'(node_count) > spdg_pkg::MAX_NODES) ? 6'(spdg_pkg::MAX_NODES) :
                 node_count;

  spdg_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item, .q_valid, .q_ready, .q_item
  );

  spdg_back u_back (
    .clk, .rst, .n_use, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_item, .busy
  );

  `SPDG_ASSERT_IMPL(a_no_out_when_idle, !busy, !out_valid)
  `SPDG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SPDG_ASSERT_IMPL(a_node_range, out_valid, out_item.node < n_use)
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the dense-graph shortest path block: directed and random loads and runs.
module tb;
  localparam int NODES = 32;
  localparam int FILL  = 16;
  localparam int LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  spdg_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spdg_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;

  logic [15:0] weights [NODES][NODES];
  logic [5:0] node_count_reg;
  spdg_pkg::out_item_t pending_results[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  int cycles = 0;

  shortest_path_dense_graph_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void predict_paths(logic [4:0] src, logic [4:0] dst);
    int unsigned dist_tab [NODES];
    bit seen [NODES];
    logic [4:0] prev [NODES];
    int n, pick;
    int unsigned sum;
    spdg_pkg::out_item_t r;
    n = (node_count_reg == 0) ? 1 :
        (int'(node_count_reg) > NODES) ? NODES : int'(node_count_reg);
    for (int i = 0; i < NODES; i++) begin
      dist_tab[i] = 32'(spdg_pkg::DIST_INF);
      seen[i] = 1'b0;
      prev[i] = '0;
    end
    if (src < n) begin
      dist_tab[src] = 0;
      prev[src] = src;
      for (int round = 0; round < n; round++) begin
        pick = n;
        for (int j = 0; j < n; j++)
          if (!seen[j] && dist_tab[j] != 32'(spdg_pkg::DIST_INF) &&
              (pick == n || dist_tab[j] < dist_tab[pick]))
            pick = j;
        if (pick == n) break;
        seen[pick] = 1'b1;
        for (int j = 0; j < n; j++) begin
          if (seen[j] || weights[pick][j] == 0) continue;
          sum = dist_tab[pick] + 32'(weights[pick][j]);
          if (sum >= 32'(spdg_pkg::DIST_INF)) sum = 32'(spdg_pkg::DIST_INF);
          if (sum < dist_tab[j]) begin
            dist_tab[j] = sum;
            prev[j] = pick[4:0];
          end
        end
        if (pick == dst) break;
      end
    end
    for (int k = 0; k < n; k++) begin
      r.node = k[4:0];
      r.distance = dist_tab[k][21:0];
      r.predecessor = prev[k];
      r.settled = seen[k];
      r.reachable = (dist_tab[k] != 32'(spdg_pkg::DIST_INF));
      r.last = (k == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  task automatic send_item(spdg_pkg::in_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 11) ? 1 : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.opcode == spdg_pkg::OP_LOAD)
      weights[it.from_node][it.to_node] = it.edge_weight;
    else
      predict_paths(it.source_node, it.target_node);
  endtask

  function automatic spdg_pkg::in_item_t rand_item();
    spdg_pkg::in_item_t it;
    it = $bits(spdg_pkg::in_item_t)'({$urandom, $urandom});
    return it;
  endfunction

  task automatic load_edge(int r, int c, int w);
    spdg_pkg::in_item_t it;
    it = rand_item();
    it.opcode = spdg_pkg::OP_LOAD;
    it.from_node = 5'(r);
    it.to_node = 5'(c);
    it.edge_weight = 16'(w);
    send_item(it);
  endtask

  task automatic run_path(int s, int d);
    spdg_pkg::in_item_t it;
    it = rand_item();
    it.opcode = spdg_pkg::OP_RUN;
    it.source_node = 5'(s);
    it.target_node = 5'(d);
    send_item(it);
  endtask

  function automatic int rand_weight();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return 0;
    if (sel < 85) return $urandom_range(1, 40);
    return $urandom_range(1, 65535);
  endfunction

  task automatic set_node_count(logic [5:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_reg = v;
  endtask

  task automatic test_fill_matrix();
    for (int r = 0; r < FILL; r++)
      for (int c = 0; c < FILL; c++)
        load_edge(r, c, rand_weight());
  endtask

  task automatic test_directed();
    set_node_count(6'd4);
    load_edge(0, 1, 16'hFFFF);
    load_edge(0, 2, 1);
    load_edge(2, 1, 16'hFFFE);
    load_edge(1, 1, 3);
    load_edge(2, 3, 5);
    load_edge(0, 3, 6);
    load_edge(3, 0, 1);
    run_path(0, 3);
    run_path(0, 31);
    run_path(10, 1);
    run_path(3, 3);
    set_node_count(6'd0);
    run_path(0, 0);
    run_path(31, 0);
    for (int c = 0; c < NODES; c++)
      load_edge(31, c, 0);
    set_node_count(6'd63);
    run_path(31, 0);
    run_path(31, 31);
    set_node_count(6'd32);
    run_path(31, 8);
    set_node_count(6'd1);
    run_path(0, 0);
  endtask

  task automatic test_random();
    logic [5:0] counts [8] = '{6'd3, 6'd1, 6'd0, 6'd8, 6'd16, 6'd5, 6'd12, 6'd16};
    for (int p = 0; p < 8; p++) begin
      set_node_count(counts[p]);
      quiet = (p == 2 || p == 3);
      for (int i = 0; i < 24; i++) begin
        if ($urandom_range(0, 99) < 70)
          load_edge($urandom_range(0, 31), $urandom_range(0, 31), rand_weight());
        else
          run_path($urandom_range(0, 99) < 10 ? $urandom_range(0, 31) :
                   $urandom_range(0, counts[p] > 8 ? 31 : 8),
                   $urandom_range(0, 31));
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= quiet || $urandom_range(0, 99) >= 11;
  end

  always @(posedge clk) begin
    spdg_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: node %0d", out_item.node);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_item.node !== e.node) begin
          $error("node: expected %0d got %0d", e.node, out_item.node);
          failed = 1'b1;
        end
        if (out_item.distance !== e.distance) begin
          $error("distance: expected %0d got %0d", e.distance, out_item.distance);
          failed = 1'b1;
        end
        if (out_item.predecessor !== e.predecessor) begin
          $error("predecessor: expected %0d got %0d", e.predecessor, out_item.predecessor);
          failed = 1'b1;
        end
        if (out_item.settled !== e.settled) begin
          $error("settled: expected %0d got %0d", e.settled, out_item.settled);
          failed = 1'b1;
        end
        if (out_item.reachable !== e.reachable) begin
          $error("reachable: expected %0d got %0d", e.reachable, out_item.reachable);
          failed = 1'b1;
        end
        if (out_item.last !== e.last) begin
          $error("last: expected %0d got %0d", e.last, out_item.last);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    node_count_reg = 6'd32;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_matrix();
    test_directed();
    test_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/spdg_pkg.sv
src/spdg_ram.sv
src/spdg_front.sv
src/spdg_back.sv
src/shortest_path_dense_graph_top.sv
tb/sv/tb.sv
